@@ rtl/line_intersection_point_defines.svh @@
// Assertion macros shared by the line intersection RTL.
// Depends on nothing; the asserting module must have clk and rst_n in scope.
`ifndef LINE_INTERSECTION_POINT_DEFINES_SVH
`define LINE_INTERSECTION_POINT_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define LIP_ASSERT_IMPLY(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> prop) \
        else $error("line intersection check failed");
`define LIP_ASSERT_NEXT(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> prop) \
        else $error("line intersection check failed");
`else
`define LIP_ASSERT_IMPLY(label, cond, prop)
`define LIP_ASSERT_NEXT(label, cond, prop)
`endif

`endif

@@ rtl/lip_pkg.sv @@
// Shared types and constants for the line intersection block.
// Used by the divider cells, the divider chain and the top level.
package lip_pkg;

    localparam int COORD_W = 32;
    localparam int DIFF_W  = 33;
    localparam int QUO_W   = 32;
    localparam int EPS_W   = 16;
    localparam int DIV_LAT = QUO_W + 2;

    localparam logic [EPS_W-1:0]   EPS_RESET = 16'd7;
    localparam logic [COORD_W-1:0] SAT_MAX   = 32'h7FFF_FFFF;
    localparam logic [COORD_W-1:0] SAT_MIN   = 32'h8000_0000;

    typedef enum logic [1:0] {
        ST_OK            = 2'd0,
        ST_PARALLEL      = 2'd1,
        ST_BOTH_VERTICAL = 2'd2
    } status_t;

    typedef struct packed {
        logic valid;
        logic neg;
        logic ovf;
    } div_ctl_t;

endpackage

@@ rtl/lip_div_cell.sv @@
// One restoring division step: brings in one numerator bit and yields one quotient bit.
// Depends on lip_pkg.
module lip_div_cell #(
    parameter int DEN_W  = 33,
    parameter int SIDE_W = 1
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  lip_pkg::div_ctl_t           in_ctl,
    input  logic [DEN_W-1:0]            in_rem,
    input  logic [DEN_W-1:0]            in_den,
    input  logic [lip_pkg::QUO_W-1:0]   in_bits,
    input  logic [lip_pkg::QUO_W-1:0]   in_quo,
    input  logic [SIDE_W-1:0]           in_side,
    output lip_pkg::div_ctl_t           out_ctl,
    output logic [DEN_W-1:0]            out_rem,
    output logic [DEN_W-1:0]            out_den,
    output logic [lip_pkg::QUO_W-1:0]   out_bits,
    output logic [lip_pkg::QUO_W-1:0]   out_quo,
    output logic [SIDE_W-1:0]           out_side
);
    import lip_pkg::*;

    div_ctl_t           ctl_reg;
    logic [DEN_W-1:0]   rem_reg, rem_next;
    logic [DEN_W-1:0]   den_reg;
    logic [QUO_W-1:0]   bits_reg, bits_next;
    logic [QUO_W-1:0]   quo_reg, quo_next;
    logic [SIDE_W-1:0]  side_reg;
    logic [DEN_W:0]     trial;
    logic [DEN_W:0]     diff;
    logic               take;

    always_comb
    begin
        trial     = {in_rem, in_bits[QUO_W-1]};
        diff      = trial - {1'b0, in_den};
        take      = (trial >= {1'b0, in_den});
        rem_next  = take ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        bits_next = {in_bits[QUO_W-2:0], 1'b0};
        quo_next  = {in_quo[QUO_W-2:0], take};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else
        begin
            ctl_reg <= in_ctl;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        den_reg  <= in_den;
        bits_reg <= bits_next;
        quo_reg  <= quo_next;
        side_reg <= in_side;
    end

    assign out_ctl  = ctl_reg;
    assign out_rem  = rem_reg;
    assign out_den  = den_reg;
    assign out_bits = bits_reg;
    assign out_quo  = quo_reg;
    assign out_side = side_reg;

endmodule

@@ rtl/lip_div.sv @@
// Pipelined sign-magnitude divider: a row of lip_div_cell stages, one quotient bit each,
// with an overflow check in front and signed 32-bit saturation behind. Depends on lip_pkg.
module lip_div #(
    parameter int NUM_W  = 49,
    parameter int DEN_W  = 33,
    parameter int SIDE_W = 1
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic [NUM_W-1:0]                in_num,
    input  logic [DEN_W-1:0]                in_den,
    input  logic                            in_neg,
    input  logic [SIDE_W-1:0]               in_side,
    output logic                            out_valid,
    output logic signed [lip_pkg::QUO_W-1:0] out_quo,
    output logic [SIDE_W-1:0]               out_side
);
    import lip_pkg::*;

    div_ctl_t           ctl_s  [0:QUO_W];
    logic [DEN_W-1:0]   rem_s  [0:QUO_W];
    logic [DEN_W-1:0]   den_s  [0:QUO_W];
    logic [QUO_W-1:0]   bits_s [0:QUO_W];
    logic [QUO_W-1:0]   quo_s  [0:QUO_W];
    logic [SIDE_W-1:0]  side_s [0:QUO_W];

    div_ctl_t           ctl0_reg, ctl0_next;
    logic [DEN_W-1:0]   rem0_reg, rem0_next;
    logic [DEN_W-1:0]   den0_reg;
    logic [QUO_W-1:0]   bits0_reg;
    logic [SIDE_W-1:0]  side0_reg;
    logic               vld_out_reg;
    logic [QUO_W-1:0]   quo_out_reg, quo_out_next;
    logic [SIDE_W-1:0]  side_out_reg;
    logic [QUO_W-1:0]   q_last;

    // The part of the numerator above the quotient field must be below the divisor,
    // otherwise the quotient does not fit and the result saturates.
    always_comb
    begin
        rem0_next       = DEN_W'(in_num[NUM_W-1:QUO_W]);
        ctl0_next.valid = in_valid;
        ctl0_next.neg   = in_neg;
        ctl0_next.ovf   = (rem0_next >= in_den);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl0_reg    <= '0;
            vld_out_reg <= 1'b0;
        end
        else
        begin
            ctl0_reg    <= ctl0_next;
            vld_out_reg <= ctl_s[QUO_W].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        rem0_reg     <= rem0_next;
        den0_reg     <= in_den;
        bits0_reg    <= in_num[QUO_W-1:0];
        side0_reg    <= in_side;
        quo_out_reg  <= quo_out_next;
        side_out_reg <= side_s[QUO_W];
    end

    assign ctl_s[0]  = ctl0_reg;
    assign rem_s[0]  = rem0_reg;
    assign den_s[0]  = den0_reg;
    assign bits_s[0] = bits0_reg;
    assign quo_s[0]  = '0;
    assign side_s[0] = side0_reg;

    for (genvar i = 0; i < QUO_W; i++)
    begin : g_cell
        lip_div_cell #(
            .DEN_W  (DEN_W),
            .SIDE_W (SIDE_W)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .in_ctl   (ctl_s[i]),
            .in_rem   (rem_s[i]),
            .in_den   (den_s[i]),
            .in_bits  (bits_s[i]),
            .in_quo   (quo_s[i]),
            .in_side  (side_s[i]),
            .out_ctl  (ctl_s[i+1]),
            .out_rem  (rem_s[i+1]),
            .out_den  (den_s[i+1]),
            .out_bits (bits_s[i+1]),
            .out_quo  (quo_s[i+1]),
            .out_side (side_s[i+1])
        );
    end

    always_comb
    begin
        q_last = quo_s[QUO_W];
        if (ctl_s[QUO_W].ovf || q_last[QUO_W-1])
        begin
            quo_out_next = ctl_s[QUO_W].neg ? SAT_MIN : SAT_MAX;
        end
        else
        begin
            quo_out_next = ctl_s[QUO_W].neg ? (-q_last) : q_last;
        end
    end

    assign out_valid = vld_out_reg;
    assign out_quo   = $signed(quo_out_reg);
    assign out_side  = side_out_reg;

endmodule

@@ rtl/line_intersection_point.sv @@
// Top level of the line intersection block: difference, slope, solve and line stages.
// Depends on lip_pkg, lip_div, lip_div_cell and line_intersection_point_defines.svh.
//
// Usage:
//   An item (two lines, each through two Q16.16 points) is taken at a rising edge
//   with start high and busy low. busy stays low, so one item may be taken on
//   every cycle; items flow through a fixed pipeline and never wait on each other.
//   The result (cross_x, cross_y, status) is shown for one cycle with done high,
//   in the order items came in. Each item passes through the two chained dividers,
//   each a row of 32 one-bit cells plus an entry and a saturation stage, and ten
//   stages of arithmetic. Throughput is one item per clock.
//   The epsilon register is written on its own channel (cfg_valid, cfg_ready,
//   cfg_data); cfg_ready is always high. Write it only while no item is in flight.
//   Reset clears every valid flag in the pipeline and sets epsilon to 7.
//   The receiver cannot stall: each result must be taken in the cycle it appears.
`include "line_intersection_point_defines.svh"

module line_intersection_point #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic signed [lip_pkg::COORD_W-1:0]    ax,
    input  logic signed [lip_pkg::COORD_W-1:0]    ay,
    input  logic signed [lip_pkg::COORD_W-1:0]    bx,
    input  logic signed [lip_pkg::COORD_W-1:0]    by,
    input  logic signed [lip_pkg::COORD_W-1:0]    cx,
    input  logic signed [lip_pkg::COORD_W-1:0]    cy,
    input  logic signed [lip_pkg::COORD_W-1:0]    px,
    input  logic signed [lip_pkg::COORD_W-1:0]    py,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [lip_pkg::EPS_W-1:0]             cfg_data,
    output logic                                  done,
    output logic signed [lip_pkg::COORD_W-1:0]    cross_x,
    output logic signed [lip_pkg::COORD_W-1:0]    cross_y,
    output logic [1:0]                            status
);
    import lip_pkg::*;

    localparam int SLOPE_NUM_W = DIFF_W + FRAC_BITS;
    localparam int PROD_W      = 2 * COORD_W;
    localparam int TS_W        = PROD_W - FRAC_BITS;
    localparam int NUMX_W      = TS_W + 1;
    localparam int XDIV_NUM_W  = NUMX_W + FRAC_BITS;
    localparam int LP_W        = COORD_W + DIFF_W;
    localparam int SUM_W       = NUMX_W + 1;
    localparam int LATENCY     = 2 + DIV_LAT + 4 + DIV_LAT + 4;

    typedef struct packed {
        logic signed [COORD_W-1:0] ax, ay, cx, cy;
        logic signed [DIFF_W-1:0]  dx1, dy1, dx2, dy2;
    } sa_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] ax, ay, cx, cy;
        logic [DIFF_W-1:0]         dx1m, dy1m, dx2m, dy2m;
        logic                      neg1, neg2, v1, v2;
    } sb_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] ax, ay, cx, cy;
        logic                      v1;
    } side1_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] m1, m2, ax, ay, cx, cy;
        logic                      v1, v2;
        logic signed [DIFF_W-1:0]  dm;
        logic signed [PROD_W-1:0]  p1, p2;
    } sc_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] m1, m2, ax, ay, cx, cy;
        logic                      v1, v2;
        logic [DIFF_W-1:0]         dmm;
        logic                      dmneg;
        logic signed [TS_W-1:0]    t1, t2;
        logic signed [DIFF_W-1:0]  cyay;
    } sd_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] m1, m2, ax, ay, cx, cy;
        logic                      v1, v2;
        logic [DIFF_W-1:0]         dmm;
        logic                      dmneg;
        logic signed [NUMX_W-1:0]  num;
        logic                      par;
    } se_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] m1, m2, ax, ay, cx, cy;
        logic                      v1, v2, par;
    } side3_t;

    typedef struct packed {
        side3_t                    side;
        logic [NUMX_W-1:0]         numm;
        logic [DIFF_W-1:0]         dmm;
        logic                      neg;
    } sf_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] m, x, y0;
        logic signed [DIFF_W-1:0]  d;
        status_t                   st;
    } sg_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] x, y0;
        logic signed [LP_W-1:0]    prod;
        status_t                   st;
    } sh_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] x, y0;
        logic signed [NUMX_W-1:0]  ts;
        status_t                   st;
    } si_t;

    logic [EPS_W-1:0]          eps_reg, eps_next;
    logic signed [DIFF_W-1:0]  eps_s;
    sa_t a_reg, a_next;
    sb_t b_reg, b_next;
    sc_t c_reg, c_next;
    sd_t d_reg, d_next;
    se_t e_reg, e_next;
    sf_t f_reg, f_next;
    sg_t g_reg, g_next;
    sh_t h_reg, h_next;
    si_t i_reg, i_next;
    logic a_vld_reg, b_vld_reg, c_vld_reg, d_vld_reg, e_vld_reg, f_vld_reg;
    logic g_vld_reg, h_vld_reg, i_vld_reg, done_reg;
    logic signed [COORD_W-1:0] cross_x_reg, cross_x_next;
    logic signed [COORD_W-1:0] cross_y_reg, cross_y_next;
    status_t                   status_reg;

    logic                      div1_valid, div2_valid, div3_valid;
    logic signed [QUO_W-1:0]   div1_quo, div2_quo, div3_quo;
    logic [$bits(side1_t)-1:0] div1_side;
    logic                      div2_side;
    logic [$bits(side3_t)-1:0] div3_side;
    side1_t                    s1o;
    side3_t                    s3o;

    logic signed [PROD_W-1:0]  pb1, pb2;
    logic signed [LP_W-1:0]    pbl;
    logic signed [SUM_W-1:0]   ysum;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign eps_next  = cfg_valid ? cfg_data : eps_reg;
    assign eps_s     = $signed(DIFF_W'(eps_reg));

    // Differences of the endpoints.
    always_comb
    begin
        a_next.ax  = ax;
        a_next.ay  = ay;
        a_next.cx  = cx;
        a_next.cy  = cy;
        a_next.dx1 = $signed({ax[COORD_W-1], ax}) - $signed({bx[COORD_W-1], bx});
        a_next.dy1 = $signed({ay[COORD_W-1], ay}) - $signed({by[COORD_W-1], by});
        a_next.dx2 = $signed({cx[COORD_W-1], cx}) - $signed({px[COORD_W-1], px});
        a_next.dy2 = $signed({cy[COORD_W-1], cy}) - $signed({py[COORD_W-1], py});
    end

    // Magnitudes and signs for the slope dividers; a line is vertical when its
    // x difference lies strictly between minus and plus epsilon, or is zero.
    always_comb
    begin
        b_next.ax   = a_reg.ax;
        b_next.ay   = a_reg.ay;
        b_next.cx   = a_reg.cx;
        b_next.cy   = a_reg.cy;
        b_next.dx1m = a_reg.dx1[DIFF_W-1] ? DIFF_W'(-a_reg.dx1) : DIFF_W'(a_reg.dx1);
        b_next.dy1m = a_reg.dy1[DIFF_W-1] ? DIFF_W'(-a_reg.dy1) : DIFF_W'(a_reg.dy1);
        b_next.dx2m = a_reg.dx2[DIFF_W-1] ? DIFF_W'(-a_reg.dx2) : DIFF_W'(a_reg.dx2);
        b_next.dy2m = a_reg.dy2[DIFF_W-1] ? DIFF_W'(-a_reg.dy2) : DIFF_W'(a_reg.dy2);
        b_next.neg1 = a_reg.dx1[DIFF_W-1] ^ a_reg.dy1[DIFF_W-1];
        b_next.neg2 = a_reg.dx2[DIFF_W-1] ^ a_reg.dy2[DIFF_W-1];
        b_next.v1   = (a_reg.dx1 == '0) ||
                      (($signed(a_reg.dx1) < eps_s) && ($signed(a_reg.dx1) > -eps_s));
        b_next.v2   = (a_reg.dx2 == '0) ||
                      (($signed(a_reg.dx2) < eps_s) && ($signed(a_reg.dx2) > -eps_s));
    end

    lip_div #(
        .NUM_W  (SLOPE_NUM_W),
        .DEN_W  (DIFF_W),
        .SIDE_W ($bits(side1_t))
    ) u_div_slope1 (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (b_vld_reg),
        .in_num    ({b_reg.dy1m, {FRAC_BITS{1'b0}}}),
        .in_den    (b_reg.dx1m),
        .in_neg    (b_reg.neg1),
        .in_side   ({b_reg.ax, b_reg.ay, b_reg.cx, b_reg.cy, b_reg.v1}),
        .out_valid (div1_valid),
        .out_quo   (div1_quo),
        .out_side  (div1_side)
    );

    lip_div #(
        .NUM_W  (SLOPE_NUM_W),
        .DEN_W  (DIFF_W),
        .SIDE_W (1)
    ) u_div_slope2 (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (b_vld_reg),
        .in_num    ({b_reg.dy2m, {FRAC_BITS{1'b0}}}),
        .in_den    (b_reg.dx2m),
        .in_neg    (b_reg.neg2),
        .in_side   (b_reg.v2),
        .out_valid (div2_valid),
        .out_quo   (div2_quo),
        .out_side  (div2_side)
    );

    assign s1o = div1_side;

    always_comb
    begin
        c_next.m1 = div1_quo;
        c_next.m2 = div2_quo;
        c_next.ax = s1o.ax;
        c_next.ay = s1o.ay;
        c_next.cx = s1o.cx;
        c_next.cy = s1o.cy;
        c_next.v1 = s1o.v1;
        c_next.v2 = div2_side;
        c_next.dm = $signed({div1_quo[QUO_W-1], div1_quo}) -
                    $signed({div2_quo[QUO_W-1], div2_quo});
        c_next.p1 = $signed(div1_quo) * $signed(s1o.ax);
        c_next.p2 = $signed(div2_quo) * $signed(s1o.cx);
    end

    // Truncation toward zero: negative products get a bias of all ones below the point.
    always_comb
    begin
        pb1 = c_reg.p1 + $signed({{TS_W{1'b0}}, {FRAC_BITS{c_reg.p1[PROD_W-1]}}});
        pb2 = c_reg.p2 + $signed({{TS_W{1'b0}}, {FRAC_BITS{c_reg.p2[PROD_W-1]}}});
        d_next.m1    = c_reg.m1;
        d_next.m2    = c_reg.m2;
        d_next.ax    = c_reg.ax;
        d_next.ay    = c_reg.ay;
        d_next.cx    = c_reg.cx;
        d_next.cy    = c_reg.cy;
        d_next.v1    = c_reg.v1;
        d_next.v2    = c_reg.v2;
        d_next.dmm   = c_reg.dm[DIFF_W-1] ? DIFF_W'(-c_reg.dm) : DIFF_W'(c_reg.dm);
        d_next.dmneg = c_reg.dm[DIFF_W-1];
        d_next.t1    = pb1[PROD_W-1:FRAC_BITS];
        d_next.t2    = pb2[PROD_W-1:FRAC_BITS];
        d_next.cyay  = $signed({c_reg.cy[COORD_W-1], c_reg.cy}) -
                       $signed({c_reg.ay[COORD_W-1], c_reg.ay});
    end

    always_comb
    begin
        e_next.m1    = d_reg.m1;
        e_next.m2    = d_reg.m2;
        e_next.ax    = d_reg.ax;
        e_next.ay    = d_reg.ay;
        e_next.cx    = d_reg.cx;
        e_next.cy    = d_reg.cy;
        e_next.v1    = d_reg.v1;
        e_next.v2    = d_reg.v2;
        e_next.dmm   = d_reg.dmm;
        e_next.dmneg = d_reg.dmneg;
        e_next.num   = $signed({d_reg.t1[TS_W-1], d_reg.t1}) -
                       $signed({d_reg.t2[TS_W-1], d_reg.t2}) +
                       $signed({{(NUMX_W-DIFF_W){d_reg.cyay[DIFF_W-1]}}, d_reg.cyay});
        e_next.par   = (d_reg.dmm <= DIFF_W'(eps_reg));
    end

    always_comb
    begin
        f_next.side.m1  = e_reg.m1;
        f_next.side.m2  = e_reg.m2;
        f_next.side.ax  = e_reg.ax;
        f_next.side.ay  = e_reg.ay;
        f_next.side.cx  = e_reg.cx;
        f_next.side.cy  = e_reg.cy;
        f_next.side.v1  = e_reg.v1;
        f_next.side.v2  = e_reg.v2;
        f_next.side.par = e_reg.par;
        f_next.numm     = e_reg.num[NUMX_W-1] ? NUMX_W'(-e_reg.num) : NUMX_W'(e_reg.num);
        f_next.dmm      = e_reg.dmm;
        f_next.neg      = e_reg.num[NUMX_W-1] ^ e_reg.dmneg;
    end

    lip_div #(
        .NUM_W  (XDIV_NUM_W),
        .DEN_W  (DIFF_W),
        .SIDE_W ($bits(side3_t))
    ) u_div_cross (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_vld_reg),
        .in_num    ({f_reg.numm, {FRAC_BITS{1'b0}}}),
        .in_den    (f_reg.dmm),
        .in_neg    (f_reg.neg),
        .in_side   (f_reg.side),
        .out_valid (div3_valid),
        .out_quo   (div3_quo),
        .out_side  (div3_side)
    );

    assign s3o = div3_side;

    // Pick the line that y is read from; a vertical line fixes x outright.
    always_comb
    begin
        g_next.m  = s3o.m1;
        g_next.x  = div3_quo;
        g_next.y0 = s3o.ay;
        g_next.st = ST_OK;
        g_next.d  = $signed({div3_quo[QUO_W-1], div3_quo}) -
                    $signed({s3o.ax[COORD_W-1], s3o.ax});
        if (s3o.v1 && s3o.v2)
        begin
            g_next.st = ST_BOTH_VERTICAL;
        end
        else if (s3o.v1)
        begin
            g_next.m  = s3o.m2;
            g_next.x  = s3o.ax;
            g_next.y0 = s3o.cy;
            g_next.d  = $signed({s3o.ax[COORD_W-1], s3o.ax}) -
                        $signed({s3o.cx[COORD_W-1], s3o.cx});
        end
        else if (s3o.v2)
        begin
            g_next.x  = s3o.cx;
            g_next.d  = $signed({s3o.cx[COORD_W-1], s3o.cx}) -
                        $signed({s3o.ax[COORD_W-1], s3o.ax});
        end
        else if (s3o.par)
        begin
            g_next.st = ST_PARALLEL;
        end
    end

    always_comb
    begin
        h_next.x    = g_reg.x;
        h_next.y0   = g_reg.y0;
        h_next.st   = g_reg.st;
        h_next.prod = $signed(g_reg.m) * $signed(g_reg.d);
    end

    always_comb
    begin
        pbl       = h_reg.prod + $signed({{NUMX_W{1'b0}}, {FRAC_BITS{h_reg.prod[LP_W-1]}}});
        i_next.x  = h_reg.x;
        i_next.y0 = h_reg.y0;
        i_next.st = h_reg.st;
        i_next.ts = pbl[LP_W-1:FRAC_BITS];
    end

    always_comb
    begin
        ysum = $signed({i_reg.ts[NUMX_W-1], i_reg.ts}) +
               $signed({{(SUM_W-COORD_W){i_reg.y0[COORD_W-1]}}, i_reg.y0});
        if ((ysum[SUM_W-1:COORD_W-1] == '0) || (ysum[SUM_W-1:COORD_W-1] == '1))
        begin
            cross_y_next = ysum[COORD_W-1:0];
        end
        else
        begin
            cross_y_next = ysum[SUM_W-1] ? SAT_MIN : SAT_MAX;
        end
        cross_x_next = i_reg.x;
        if (i_reg.st != ST_OK)
        begin
            cross_x_next = '0;
            cross_y_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eps_reg   <= EPS_RESET;
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
            c_vld_reg <= 1'b0;
            d_vld_reg <= 1'b0;
            e_vld_reg <= 1'b0;
            f_vld_reg <= 1'b0;
            g_vld_reg <= 1'b0;
            h_vld_reg <= 1'b0;
            i_vld_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            eps_reg   <= eps_next;
            a_vld_reg <= start && !busy;
            b_vld_reg <= a_vld_reg;
            c_vld_reg <= div1_valid && div2_valid;
            d_vld_reg <= c_vld_reg;
            e_vld_reg <= d_vld_reg;
            f_vld_reg <= e_vld_reg;
            g_vld_reg <= div3_valid;
            h_vld_reg <= g_vld_reg;
            i_vld_reg <= h_vld_reg;
            done_reg  <= i_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg       <= a_next;
        b_reg       <= b_next;
        c_reg       <= c_next;
        d_reg       <= d_next;
        e_reg       <= e_next;
        f_reg       <= f_next;
        g_reg       <= g_next;
        h_reg       <= h_next;
        i_reg       <= i_next;
        cross_x_reg <= cross_x_next;
        cross_y_reg <= cross_y_next;
        status_reg  <= i_reg.st;
    end

    assign done    = done_reg;
    assign cross_x = cross_x_reg;
    assign cross_y = cross_y_reg;
    assign status  = status_reg;

    `LIP_ASSERT_IMPLY(a_done_has_item, done, $past(start && !busy, LATENCY))
    `LIP_ASSERT_IMPLY(a_error_zeroes, done && (status != ST_OK), (cross_x == '0) && (cross_y == '0))
    `LIP_ASSERT_IMPLY(a_both_vertical, start && !busy && (ax == bx) && (cx == px), ##LATENCY (done && (status == ST_BOTH_VERTICAL)))
    `LIP_ASSERT_NEXT(a_eps_write, cfg_valid && cfg_ready, eps_reg == $past(cfg_data))

endmodule
